// ----- hw/rtl/vcw_pkg.sv -----
`default_nettype none

package vcw_pkg;

   localparam int COORD_W      = 12;
   localparam int RADIUS_W     = 12;
   localparam int COLOR_W      = 9;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam int WIDTH_RESET  = 1920;
   localparam int HEIGHT_RESET = 1080;
   localparam int FADE_RESET   = 256;

   localparam int R_FRAC       = 14;
   localparam int HALF_SQRT3   = 56756;
   localparam int ONE_Q16      = 65536;
   localparam int HALF_Q16     = 32768;
   localparam int COS_QUO_W    = 18;
   localparam int FADE_QUO_W   = 9;
   localparam int FADE_NUM_W   = 21;
   localparam int CHAN_W       = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_FADE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/vector_to_color_wheel_core.sv -----
// Channel  Ports                          Transfer
// req      start, busy, req_data          start high and busy low at a clock edge
// rsp      rsp_valid, rsp_data            one-cycle strobe, always taken
// csr      csr_valid, csr_ready, csr_*    valid and ready both high at a clock edge
//
// A point may enter on every clock; busy stays low.
// The pipeline runs through the square root stages (one root bit each), the 18 cosine divide
// stages and the 9 fade divide stages.
// Synchronous reset empties the pipeline and loads the register defaults.
// Results cannot be stalled, so the pipeline never stops.
`default_nettype none

module vector_to_color_wheel_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire vcw_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   output vcw_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [vcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CB     = vcw_pkg::COORD_W;
   localparam int RW     = CB + 15;
   localparam int NW     = CB + 18;
   localparam int MW     = NW - 1;
   localparam int NUMW   = CB + 32;
   localparam int PW     = RW + 21;
   localparam int CW     = vcw_pkg::CHAN_W;
   localparam int QW     = vcw_pkg::COS_QUO_W;
   localparam int FW     = vcw_pkg::RADIUS_W;
   localparam int TW     = vcw_pkg::FADE_NUM_W;
   localparam int OW     = vcw_pkg::COLOR_W;
   localparam int SQ_SIDE = 4 + 3 * MW;

   logic [CB-1:0] width_ff;
   logic [CB-1:0] height_ff;
   logic [FW-1:0] fade_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CB'(vcw_pkg::WIDTH_RESET);
         height_ff <= CB'(vcw_pkg::HEIGHT_RESET);
         fade_ff   <= FW'(vcw_pkg::FADE_RESET);
      end else if (csr_valid) begin
         unique case (vcw_pkg::csr_index_type'(csr_index))
            vcw_pkg::REG_WIDTH:  width_ff  <= csr_wdata[CB-1:0];
            vcw_pkg::REG_HEIGHT: height_ff <= csr_wdata[CB-1:0];
            vcw_pkg::REG_FADE:   fade_ff   <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   // Offsets from the surface center.
   logic                 v0_ff;
   logic signed [CB:0]   dx0_ff, dy0_ff;
   logic [CB:0]          dx0_in, dy0_in;

   assign dx0_in = {1'b0, req_data.point_x[CB-1:0]} - {2'b00, width_ff[CB-1:1]};
   assign dy0_in = {1'b0, req_data.point_y[CB-1:0]} - {2'b00, height_ff[CB-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      dx0_ff <= dx0_in;
      dy0_ff <= dy0_in;
   end

   // Squares and the sine-side product.
   logic                   v1_ff, zero1_ff;
   logic [2*CB-1:0]        dx2_ff, dy2_ff;
   logic signed [NW-1:0]   side1_ff, dx1_ff;
   logic signed [2*CB+1:0] dxe, dye, dx2_in, dy2_in;
   logic signed [NW-1:0]   dyn, side_in;

   assign dxe     = (2*CB+2)'(dx0_ff);
   assign dye     = (2*CB+2)'(dy0_ff);
   assign dx2_in  = dxe * dxe;
   assign dy2_in  = dye * dye;
   assign dyn     = NW'(dy0_ff);
   assign side_in = dyn * NW'(vcw_pkg::HALF_SQRT3);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff   <= dx2_in[2*CB-1:0];
      dy2_ff   <= dy2_in[2*CB-1:0];
      side1_ff <= side_in;
      dx1_ff   <= NW'(dx0_ff);
      zero1_ff <= (dx0_ff == '0) || (dy0_ff == '0);
   end

   // Distance radicand and the three cosine numerators.
   logic                  v2_ff, zero2_ff;
   logic [2*RW-1:0]       rad2_ff;
   logic [MW-1:0]         mag2_ff [3];
   logic [2:0]            neg2_ff;
   logic [2*CB:0]         sq_in;
   logic signed [NW-1:0]  num_in [3];
   logic signed [NW-1:0]  half_in;

   assign sq_in     = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign half_in   = dx1_ff <<< 15;
   assign num_in[0] = dx1_ff <<< 16;
   assign num_in[1] = -half_in - side1_ff;
   assign num_in[2] = -half_in + side1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad2_ff  <= {1'b0, sq_in, 28'd0};
      zero2_ff <= zero1_ff;
      for (int k = 0; k < 3; k++) begin
         neg2_ff[k] <= num_in[k][NW-1];
         mag2_ff[k] <= num_in[k][NW-1] ? MW'(-num_in[k]) : MW'(num_in[k]);
      end
   end

   logic              sq_valid;
   logic [RW-1:0]     sq_root;
   logic [SQ_SIDE-1:0] sq_side;

   vcw_sqrt #(
      .ROOT_W (RW),
      .SIDE_W (SQ_SIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rad    (rad2_ff),
      .in_side   ({zero2_ff, neg2_ff, mag2_ff[0], mag2_ff[1], mag2_ff[2]}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Rounded dividends for the cosine quotients.
   logic             v3_ff, zero3_ff;
   logic [RW-1:0]    r3_ff;
   logic [2:0]       neg3_ff;
   logic [NUMW-1:0]  num3_ff [3];
   logic [MW-1:0]    mag3 [3];

   assign mag3[0] = sq_side[3*MW-1 -: MW];
   assign mag3[1] = sq_side[2*MW-1 -: MW];
   assign mag3[2] = sq_side[MW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      r3_ff    <= sq_root;
      zero3_ff <= sq_side[SQ_SIDE-1];
      neg3_ff  <= sq_side[SQ_SIDE-2 -: 3];
      for (int k = 0; k < 3; k++) begin
         num3_ff[k] <= NUMW'({mag3[k], 14'd0}) + NUMW'(sq_root[RW-1:1]);
      end
   end

   logic              cd_valid, cd_valid1, cd_valid2;
   logic [QW-1:0]     cd_quo [3];
   logic [RW+1:0]     cd_side0;
   logic              cd_neg1, cd_neg2;

   vcw_div #(.NUM_W(NUMW), .DEN_W(RW), .QUO_W(QW), .SIDE_W(RW + 2)) u_cos_div0 (
      .clock (clock), .reset (reset), .in_valid (v3_ff), .in_num (num3_ff[0]),
      .in_den (r3_ff), .in_side ({zero3_ff, neg3_ff[0], r3_ff}),
      .out_valid (cd_valid), .out_quo (cd_quo[0]), .out_side (cd_side0)
   );

   vcw_div #(.NUM_W(NUMW), .DEN_W(RW), .QUO_W(QW), .SIDE_W(1)) u_cos_div1 (
      .clock (clock), .reset (reset), .in_valid (v3_ff), .in_num (num3_ff[1]),
      .in_den (r3_ff), .in_side (neg3_ff[1]),
      .out_valid (cd_valid1), .out_quo (cd_quo[1]), .out_side (cd_neg1)
   );

   vcw_div #(.NUM_W(NUMW), .DEN_W(RW), .QUO_W(QW), .SIDE_W(1)) u_cos_div2 (
      .clock (clock), .reset (reset), .in_valid (v3_ff), .in_num (num3_ff[2]),
      .in_den (r3_ff), .in_side (neg3_ff[2]),
      .out_valid (cd_valid2), .out_quo (cd_quo[2]), .out_side (cd_neg2)
   );

   // Offset by one half, clamp, and decide on fading.
   logic                 v4_ff, fade4_ff;
   logic [RW-1:0]        r4_ff;
   logic [CW-1:0]        cu4_ff [3];
   logic [CW-1:0]        cu_in [3];
   logic [2:0]           cd_neg;
   logic                 cd_zero;
   logic [RW-1:0]        cd_r;
   logic [RW+FW-1:0]     fade_lim;

   assign cd_neg   = {cd_neg2, cd_neg1, cd_side0[RW]};
   assign cd_zero  = cd_side0[RW+1];
   assign cd_r     = cd_side0[RW-1:0];
   assign fade_lim = (RW+FW)'({fade_ff, 14'd0});

   always_comb begin
      logic signed [QW+1:0] c;
      for (int k = 0; k < 3; k++) begin
         c = cd_neg[k] ? -(QW+2)'(cd_quo[k]) : (QW+2)'(cd_quo[k]);
         c = c + (QW+2)'(vcw_pkg::HALF_Q16);
         if (c < 0) begin
            cu_in[k] = '0;
         end else if (c > (QW+2)'(vcw_pkg::ONE_Q16)) begin
            cu_in[k] = CW'(vcw_pkg::ONE_Q16);
         end else begin
            cu_in[k] = c[CW-1:0];
         end
      end
      if (cd_zero) begin
         cu_in[0] = CW'(vcw_pkg::ONE_Q16);
         cu_in[1] = '0;
         cu_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      r4_ff    <= cd_r;
      fade4_ff <= (RW+FW)'(cd_r) < fade_lim;
      cu4_ff   <= cu_in;
   end

   // Scale by the distance; plain rounding for the unfaded path.
   logic           v5_ff, fade5_ff;
   logic [TW-1:0]  t5_ff [3];
   logic [OW-1:0]  plain5_ff [3];
   logic [PW-1:0]  prod_in [3];
   logic [CW:0]    round_in [3];

   for (genvar k = 0; k < 3; k++) begin : g_scale
      assign prod_in[k]  = PW'(cu4_ff[k]) * PW'(r4_ff) + PW'({fade_ff, 21'd0});
      assign round_in[k] = {1'b0, cu4_ff[k]} + (CW+1)'(128);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      fade5_ff <= fade4_ff;
      for (int k = 0; k < 3; k++) begin
         t5_ff[k]     <= prod_in[k][22 +: TW];
         plain5_ff[k] <= round_in[k][CW-1:8];
      end
   end

   logic             fd_valid [3];
   logic [OW-1:0]    fd_quo [3];
   logic [OW:0]      fd_side [3];

   for (genvar k = 0; k < 3; k++) begin : g_fade
      vcw_div #(
         .NUM_W  (TW),
         .DEN_W  (FW),
         .QUO_W  (vcw_pkg::FADE_QUO_W),
         .SIDE_W (OW + 1)
      ) u_fade_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v5_ff),
         .in_num    (t5_ff[k]),
         .in_den    (fade_ff),
         .in_side   ({fade5_ff, plain5_ff[k]}),
         .out_valid (fd_valid[k]),
         .out_quo   (fd_quo[k]),
         .out_side  (fd_side[k])
      );
   end

   logic             rsp_valid_ff;
   vcw_pkg::rsp_type rsp_data_ff;
   logic [OW-1:0]    color_in [3];

   for (genvar k = 0; k < 3; k++) begin : g_pick
      assign color_in[k] = fd_side[k][OW] ? fd_quo[k] : fd_side[k][OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fd_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.red   <= color_in[0];
      rsp_data_ff.green <= color_in[1];
      rsp_data_ff.blue  <= color_in[2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red <= OW'(256)) && (rsp_data.green <= OW'(256))
                    && (rsp_data.blue <= OW'(256)))
      else $error("color channel above full scale");

   a_cos_lanes: assert property (@(posedge clock) disable iff (reset)
      (cd_valid == cd_valid1) && (cd_valid == cd_valid2))
      else $error("cosine divider lanes out of step");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (fd_valid[0] == fd_valid[1]) && (fd_valid[0] == fd_valid[2]))
      else $error("fade divider lanes out of step");

   a_fade_dims: assert property (@(posedge clock) disable iff (reset)
      (fd_valid[0] && fd_side[0][OW]) |-> (fd_quo[0] <= fd_side[0][OW-1:0]))
      else $error("faded red brighter than unfaded red");

endmodule

`default_nettype wire

// ----- hw/rtl/vcw_sqrt.sv -----
`default_nettype none

module vcw_sqrt #(
   parameter int ROOT_W = 27,
   parameter int SIDE_W = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic              valid_ff [1:ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [1:ROOT_W];
   logic [REM_W-1:0]  rem_ff   [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff  [1:ROOT_W];
   logic [SIDE_W-1:0] side_ff  [1:ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic              valid_src;
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W:0]    diff;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rad_src   = in_rad;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[j];
         assign rad_src   = rad_ff[j];
         assign rem_src   = rem_ff[j];
         assign root_src  = root_ff[j];
         assign side_src  = side_ff[j];
      end

      assign rem_cat = {rem_src[ROOT_W-1:0], rad_src[RAD_W-1 -: 2]};
      assign diff    = {1'b0, rem_cat} - {1'b0, root_src, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[j+1]  <= {rad_src[RAD_W-3:0], 2'b00};
         side_ff[j+1] <= side_src;
         if (diff[REM_W]) begin
            rem_ff[j+1]  <= rem_cat;
            root_ff[j+1] <= {root_src[ROOT_W-2:0], 1'b0};
         end else begin
            rem_ff[j+1]  <= diff[REM_W-1:0];
            root_ff[j+1] <= {root_src[ROOT_W-2:0], 1'b1};
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

`default_nettype wire

// ----- hw/rtl/vcw_div.sv -----
`default_nettype none

module vcw_div #(
   parameter int NUM_W  = 21,
   parameter int DEN_W  = 12,
   parameter int QUO_W  = 9,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int REM_W = DEN_W + QUO_W;

   logic              valid_ff [1:QUO_W];
   logic [REM_W-1:0]  rem_ff   [1:QUO_W];
   logic [DEN_W-1:0]  den_ff   [1:QUO_W];
   logic [QUO_W-1:0]  quo_ff   [1:QUO_W];
   logic [SIDE_W-1:0] side_ff  [1:QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int SHIFT = QUO_W - 1 - j;
      logic              valid_src;
      logic [REM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W:0]    diff;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = REM_W'(in_num);
         assign den_src   = in_den;
         assign quo_src   = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[j];
         assign rem_src   = rem_ff[j];
         assign den_src   = den_ff[j];
         assign quo_src   = quo_ff[j];
         assign side_src  = side_ff[j];
      end

      assign diff = {1'b0, rem_src} - ((REM_W+1)'(den_src) << SHIFT);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[j+1]  <= den_src;
         side_ff[j+1] <= side_src;
         quo_ff[j+1]  <= {quo_src[QUO_W-2:0], ~diff[REM_W]};
         rem_ff[j+1]  <= diff[REM_W] ? rem_src : diff[REM_W-1:0];
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

// ----- tb/vector_to_color_wheel_checker.sv -----
`default_nettype none

module vector_to_color_wheel_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire vcw_pkg::req_type                req_data,
   input  wire logic                            rsp_valid,
   input  wire vcw_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [vcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [vcw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   fail_count,
   output int                                   colors_pending
);

   logic [11:0]      width_reg;
   logic [11:0]      height_reg;
   logic [11:0]      fade_reg;
   vcw_pkg::rsp_type color_queue[$];

   assign colors_pending = color_queue.size();

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint cosine_q16(longint num, longint unsigned radius);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = ((mag << vcw_pkg::R_FRAC) + (radius >> 1)) / radius;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic vcw_pkg::rsp_type predict_color(vcw_pkg::req_type pt);
      longint           dx;
      longint           dy;
      longint unsigned  radius;
      longint unsigned  den;
      longint           cs[3];
      longint           c;
      logic [8:0]       chan[3];
      vcw_pkg::rsp_type res;
      dx = longint'(pt.point_x) - longint'(width_reg >> 1);
      dy = longint'(pt.point_y) - longint'(height_reg >> 1);
      radius = root_floor(longint'(dx * dx + dy * dy) << (2 * vcw_pkg::R_FRAC));
      if (dx == 0 || dy == 0) begin
         cs[0] = vcw_pkg::ONE_Q16;
         cs[1] = -vcw_pkg::HALF_Q16;
         cs[2] = -vcw_pkg::HALF_Q16;
      end else begin
         cs[0] = cosine_q16(dx * vcw_pkg::ONE_Q16, radius);
         cs[1] = cosine_q16(-dx * vcw_pkg::HALF_Q16 - dy * vcw_pkg::HALF_SQRT3, radius);
         cs[2] = cosine_q16(-dx * vcw_pkg::HALF_Q16 + dy * vcw_pkg::HALF_SQRT3, radius);
      end
      for (int k = 0; k < 3; k++) begin
         c = cs[k] + vcw_pkg::HALF_Q16;
         if (c < 0) c = 0;
         if (c > vcw_pkg::ONE_Q16) c = vcw_pkg::ONE_Q16;
         if (radius < (longint'(fade_reg) << vcw_pkg::R_FRAC)) begin
            den = longint'(fade_reg) << (vcw_pkg::R_FRAC + 8);
            chan[k] = 9'((longint'(c) * radius + (den >> 1)) / den);
         end else begin
            chan[k] = 9'((c + 128) >> 8);
         end
      end
      res.red = chan[0];
      res.green = chan[1];
      res.blue = chan[2];
      return res;
   endfunction

   always @(posedge clock) begin
      vcw_pkg::rsp_type want;
      if (reset) begin
         width_reg <= 12'(vcw_pkg::WIDTH_RESET);
         height_reg <= 12'(vcw_pkg::HEIGHT_RESET);
         fade_reg <= 12'(vcw_pkg::FADE_RESET);
         color_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (vcw_pkg::csr_index_type'(csr_index))
               vcw_pkg::REG_WIDTH: width_reg <= csr_wdata[11:0];
               vcw_pkg::REG_HEIGHT: height_reg <= csr_wdata[11:0];
               vcw_pkg::REG_FADE: fade_reg <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (start && !busy) color_queue.push_back(predict_color(req_data));
         if (rsp_valid) begin
            if (color_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected color %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = color_queue.pop_front();
               if (want != rsp_data) begin
                  if (fail_count < 10) begin
                     $display("color mismatch: expected %p, got %p", want, rsp_data);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

// ----- tb/tb_vector_to_color_wheel_core.sv -----
`default_nettype none

module tb_vector_to_color_wheel_core;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   vcw_pkg::req_type                req_data;
   logic                            rsp_valid;
   vcw_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [vcw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [vcw_pkg::CSR_DATA_W-1:0]  csr_wdata;
   int                              fail_count;
   int                              colors_pending;
   int                              quiet_cycles;

   vector_to_color_wheel_core u_top (.*);
   vector_to_color_wheel_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(vcw_pkg::csr_index_type idx, int val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_point(int px, int py);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_data.point_x <= 12'(px);
      req_data.point_y <= 12'(py);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (colors_pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic random_points(int n);
      int cx;
      int cy;
      for (int i = 0; i < n; i++) begin
         cx = u_checker.width_reg / 2;
         cy = u_checker.height_reg / 2;
         case ($urandom_range(0, 4))
            0: send_point(cx, $urandom_range(0, 4095));
            1: send_point($urandom_range(0, 4095), cy);
            2: send_point(cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40) - 20);
            default: send_point($urandom_range(0, 4095), $urandom_range(0, 4095));
         endcase
      end
   endtask

   initial begin
      int settings[6][3];
      reset = 1;
      start = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_point(960, 540);
      send_point(960, 0);
      send_point(0, 540);
      send_point(4095, 540);
      send_point(960, 4095);
      send_point(0, 0);
      send_point(4095, 4095);
      send_point(0, 4095);
      send_point(4095, 0);
      send_point(1000, 560);
      send_point(961, 541);
      send_point(1200, 300);
      send_point(2730, 2730);
      send_point(1365, 1365);
      drain();
      settings = '{'{0, 0, 1}, '{4095, 4095, 4095}, '{4094, 3, 0},
                   '{100, 200, 50}, '{2048, 2048, 2000}, '{1920, 1080, 256}};
      foreach (settings[s]) begin
         write_reg(vcw_pkg::REG_WIDTH, settings[s][0] | ($urandom_range(0, 15) << 12));
         write_reg(vcw_pkg::REG_HEIGHT, settings[s][1]);
         write_reg(vcw_pkg::REG_FADE, settings[s][2]);
         send_point(settings[s][0] / 2, settings[s][1] / 2);
         random_points(125);
         drain();
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/vcw_pkg.sv
hw/rtl/vcw_sqrt.sv
hw/rtl/vcw_div.sv
hw/rtl/vector_to_color_wheel_core.sv
tb/vector_to_color_wheel_checker.sv
tb/tb_vector_to_color_wheel_core.sv
